// ===== sv/trsc_pkg.sv =====
`default_nettype none
package trsc_pkg;

  localparam int ALPHABET_SIZE = 26;
  localparam int IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int POS_W = 5;
  localparam int VAL_W = 5;
  localparam int SYM_W = 8;
  localparam int SUM_W = POS_W + 1;
  localparam int SEL_W = 2;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 8;
  localparam logic [SYM_W-1:0] LETTER_BASE = 8'd65;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_PROCESS = 2'd2
  } action_e;

  localparam logic [SEL_W-1:0] ROTOR_FIRST  = 2'd0;
  localparam logic [SEL_W-1:0] ROTOR_SECOND = 2'd1;
  localparam logic [SEL_W-1:0] ROTOR_THIRD  = 2'd2;

  localparam logic [1:0] CFG_START_FIRST  = 2'd0;
  localparam logic [1:0] CFG_START_SECOND = 2'd1;
  localparam logic [1:0] CFG_START_THIRD  = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [(1 << SUM_W)-1:0][IDX_W-1:0] mod_tab_t;

  // residue of every sum of a letter index and a position
  function automatic mod_tab_t build_mod_table();
    mod_tab_t t;
    for (int i = 0; i < (1 << SUM_W); i++) begin
      t[i] = idx_t'(i % ALPHABET_SIZE);
    end
    return t;
  endfunction

  localparam mod_tab_t MOD_TABLE = build_mod_table();

  typedef struct packed {
    logic             emit;
    logic             letter;
    logic [SYM_W-1:0] sym;
    logic [POS_W-1:0] pos2;
    logic [POS_W-1:0] pos3;
    logic             wr_en;
    logic [SEL_W-1:0] wr_sel;
    idx_t             wr_idx;
    logic [VAL_W-1:0] wr_val;
  } stage_t;

endpackage
`default_nettype wire

// ===== sv/three_rotor_substitution_cipher.sv =====
// Three-rotor substitution cipher, one byte per clock while m_axis_tready holds.
//
// Input items arrive on s_axis; tuser carries the action (load a rotor entry,
// restart the positions from the start registers, or process a symbol).
// Loads and restarts give no result; each processed symbol gives exactly one
// byte on m_axis, in order. Letters are ciphered through the three rotor
// tables and step the positions like an odometer; other bytes pass through.
//
// The tables live in three synchronous memories, one per rotor, read in
// successive pipeline stages. An entry load travels down the same stages and
// writes each table where that table is read, so ordering holds without stalls.
// An accepted item passes the a, b and c stage registers and the output register
// that drives m_axis_tvalid; throughput is one item per cycle while m_axis_tready holds.
//
// Reset empties the pipeline and clears positions and start registers; tables
// are undefined until loaded. When the receiver stalls, the four stages fill
// and s_axis_tready drops once they are all occupied.
`default_nettype none
module three_rotor_substitution_cipher (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [1:0]                      cfg_idx_i,
  input  wire logic [trsc_pkg::POS_W-1:0]      cfg_data_i,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // rotor_select[1:0], entry_index[6:2], entry_value[11:7], symbol[19:12]
  input  wire logic [trsc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // action[1:0]
  input  wire logic [1:0]                      s_axis_tuser,
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // out_symbol[7:0]
  output      logic [trsc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import trsc_pkg::*;

  logic [POS_W-1:0] start1_q, start2_q, start3_q;
  logic [POS_W-1:0] pos1_q, pos2_q, pos3_q;
  logic [POS_W-1:0] pos1_d, pos2_d, pos3_d;

  logic [VAL_W-1:0] mem1 [ALPHABET_SIZE];
  logic [VAL_W-1:0] mem2 [ALPHABET_SIZE];
  logic [VAL_W-1:0] mem3 [ALPHABET_SIZE];

  logic [VAL_W-1:0] rd1_q, rd2_q, rd3_q;
  stage_t           a_q, b_q, c_q, in_st;
  logic             va_q, vb_q, vc_q;
  logic             out_valid_q;
  logic [SYM_W-1:0] out_q;

  logic en_out, en_c, en_b, en_a, accept;

  logic [SEL_W-1:0] in_sel;
  logic [POS_W-1:0] in_eidx;
  logic [VAL_W-1:0] in_eval;
  logic [SYM_W-1:0] in_sym;
  logic             in_letter;
  logic [SYM_W-1:0] sym_off;
  idx_t             addr1, addr2, addr3;
  idx_t             adv1, adv2, adv3;

  assign en_out = !out_valid_q || m_axis_tready;
  assign en_c   = !vc_q || en_out;
  assign en_b   = !vb_q || en_c;
  assign en_a   = !va_q || en_b;
  assign s_axis_tready = en_a;
  assign accept = s_axis_tvalid && en_a;

  assign in_sel  = s_axis_tdata[1:0];
  assign in_eidx = s_axis_tdata[6:2];
  assign in_eval = s_axis_tdata[11:7];
  assign in_sym  = s_axis_tdata[19:12];

  always_comb begin
    in_letter = ({1'b0, in_sym} >= {1'b0, LETTER_BASE}) &&
                ({1'b0, in_sym} < 9'(int'(LETTER_BASE) + ALPHABET_SIZE));
    sym_off   = in_sym - LETTER_BASE;
    addr1     = MOD_TABLE[{1'b0, sym_off[POS_W-1:0]} + {1'b0, pos1_q}];
    addr2     = MOD_TABLE[{1'b0, rd1_q} + {1'b0, a_q.pos2}];
    addr3     = MOD_TABLE[{1'b0, rd2_q} + {1'b0, b_q.pos3}];

    in_st.emit   = (s_axis_tuser == ACT_PROCESS);
    in_st.letter = in_letter;
    in_st.sym    = in_sym;
    in_st.pos2   = pos2_q;
    in_st.pos3   = pos3_q;
    in_st.wr_en  = (s_axis_tuser == ACT_LOAD) && (in_sel <= ROTOR_THIRD) &&
                   ({1'b0, in_eidx} < 6'(ALPHABET_SIZE));
    in_st.wr_sel = in_sel;
    in_st.wr_idx = in_eidx[IDX_W-1:0];
    in_st.wr_val = in_eval;

    adv1 = MOD_TABLE[{1'b0, pos1_q} + 6'd1];
    adv2 = MOD_TABLE[{1'b0, pos2_q} + 6'd1];
    adv3 = MOD_TABLE[{1'b0, pos3_q} + 6'd1];

    pos1_d = pos1_q;
    pos2_d = pos2_q;
    pos3_d = pos3_q;
    if (accept) begin
      case (s_axis_tuser)
        ACT_RESTART: begin
          pos1_d = start1_q;
          pos2_d = start2_q;
          pos3_d = start3_q;
        end
        ACT_PROCESS: begin
          if (in_letter) begin
            // odometer: carry into the next rotor on wrap
            pos1_d = POS_W'(adv1);
            if (adv1 == '0) begin
              pos2_d = POS_W'(adv2);
              if (adv2 == '0) begin
                pos3_d = POS_W'(adv3);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start1_q <= '0;
      start2_q <= '0;
      start3_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_FIRST:  start1_q <= cfg_data_i;
        CFG_START_SECOND: start2_q <= cfg_data_i;
        CFG_START_THIRD:  start3_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos1_q      <= '0;
      pos2_q      <= '0;
      pos3_q      <= '0;
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos1_q <= pos1_d;
      pos2_q <= pos2_d;
      pos3_q <= pos3_d;
      if (en_a)   va_q        <= accept;
      if (en_b)   vb_q        <= va_q;
      if (en_c)   vc_q        <= vb_q;
      if (en_out) out_valid_q <= vc_q && c_q.emit;
    end
  end

  // rotor memories: each written in the stage where it is read
  always_ff @(posedge clk_i) begin
    if (en_a) begin
      rd1_q <= mem1[addr1];
      a_q   <= in_st;
    end
    if (accept && in_st.wr_en && in_st.wr_sel == ROTOR_FIRST) begin
      mem1[in_st.wr_idx] <= in_st.wr_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      rd2_q <= mem2[addr2];
      b_q   <= a_q;
    end
    if (en_b && va_q && a_q.wr_en && a_q.wr_sel == ROTOR_SECOND) begin
      mem2[a_q.wr_idx] <= a_q.wr_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      rd3_q <= mem3[addr3];
      c_q   <= b_q;
    end
    if (en_c && vb_q && b_q.wr_en && b_q.wr_sel == ROTOR_THIRD) begin
      mem3[b_q.wr_idx] <= b_q.wr_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      out_q <= c_q.letter ? (LETTER_BASE + {3'b000, rd3_q}) : c_q.sym;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  a_emit_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vc_q && c_q.emit && en_out) |=> m_axis_tvalid)
    else $error("finished symbol item did not reach the output");

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (va_q && vb_q && vc_q && m_axis_tvalid && !m_axis_tready))
    else $error("input blocked while the pipeline has room");

  a_letter_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser == ACT_PROCESS && in_letter) |=> (pos1_q != $past(pos1_q)))
    else $error("first rotor did not step on a letter");

endmodule
`default_nettype wire
